### rtl/sarm_pkg.sv
// ----------------------------------------------------------------------------
// sarm_pkg
// Shared types, codes and lookup tables of the soft-attention ring memory.
// ----------------------------------------------------------------------------
package sarm_pkg;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int GATE_W = 12;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] element_value;
    logic [15:0]        surprise;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [3:0]         out_index;
    logic               written;
    logic               last_result;
  } out_item_t;

  typedef enum logic [1:0] {OP_READ, OP_WRITE, OP_CLEAR} op_t;

  typedef struct packed {
    op_t               op;
    logic [CNT_W-1:0]  cnt;
    logic [GATE_W-1:0] gate;
  } cmd_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] val;
  } stage_wr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR,
    S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_DOT_ST,
    S_EXP_RD, S_EXP_MUL, S_EXP_W,
    S_DIV,
    S_P_RD, S_P_MUL, S_P_WR,
    S_SUM_RD, S_SUM_MUL, S_SUM_ACC, S_EMIT,
    S_WR_RD, S_WR_MUL, S_WR_ST, S_WR_SKIP
  } back_state_t;

  function automatic logic [15:0] exp2_lut(input logic [3:0] k);
    logic [15:0] r;
    unique case (k)
      4'd0:  r = 16'd65535;
      4'd1:  r = 16'd62758;
      4'd2:  r = 16'd60097;
      4'd3:  r = 16'd57549;
      4'd4:  r = 16'd55109;
      4'd5:  r = 16'd52773;
      4'd6:  r = 16'd50535;
      4'd7:  r = 16'd48393;
      4'd8:  r = 16'd46341;
      4'd9:  r = 16'd44376;
      4'd10: r = 16'd42495;
      4'd11: r = 16'd40693;
      4'd12: r = 16'd38968;
      4'd13: r = 16'd37316;
      4'd14: r = 16'd35734;
      default: r = 16'd34219;
    endcase
    return r;
  endfunction

  function automatic logic [GATE_W-1:0] tanh_lut(input logic [4:0] k);
    logic [GATE_W-1:0] r;
    unique case (k)
      5'd0:  r = 12'd0;
      5'd1:  r = 12'd1003;
      5'd2:  r = 12'd1893;
      5'd3:  r = 12'd2602;
      5'd4:  r = 12'd3119;
      5'd5:  r = 12'd3475;
      5'd6:  r = 12'd3707;
      5'd7:  r = 12'd3856;
      5'd8:  r = 12'd3949;
      5'd9:  r = 12'd4006;
      5'd10: r = 12'd4041;
      5'd11: r = 12'd4062;
      5'd12: r = 12'd4076;
      5'd13: r = 12'd4084;
      5'd14: r = 12'd4089;
      5'd15: r = 12'd4091;
      default: r = 12'd4093;
    endcase
    return r;
  endfunction

endpackage

### rtl/soft_attention_ring_memory_unit.sv
// ----------------------------------------------------------------------------
// soft_attention_ring_memory_unit
// Slot memory with dot-product softmax reads and tanh-gated ring writes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A non-last element
// leaves busy low. After a last element or a clear, busy stays high until
// the back end has finished the command; a write with a zero gate skips
// the slot update, and a query is paced by the single slot memory read port
// that the dot-product and weighted-sum passes walk one element at a time.
// Each result appears for one cycle with result_valid, in the cycle after the
// back end finishes it, and cannot be held off by the receiver; a read
// gives DIM results, a write or clear gives one.
module soft_attention_ring_memory_unit #(
  parameter int SLOTS = 16,
  parameter int DIM   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sarm_pkg::in_item_t  item,
  output logic                result_valid,
  output sarm_pkg::out_item_t result
);
  import sarm_pkg::*;

  stage_wr_t stage_wr;
  logic      push;
  cmd_t      cmd_f;
  cmd_t      cmd_b;
  logic      nonempty;
  logic      take;
  logic      idle;
  logic      accept;

  assign accept = start && !busy;
  assign busy   = nonempty || !idle;

  sarm_front #(.DIM(DIM)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .stage_wr (stage_wr),
    .push     (push),
    .cmd      (cmd_f)
  );

  sarm_cmd_q u_q (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (cmd_f),
    .pop      (take),
    .dout     (cmd_b),
    .nonempty (nonempty)
  );

  sarm_back #(.SLOTS(SLOTS), .DIM(DIM)) u_back (
    .clk          (clk),
    .rst          (rst),
    .stage_wr     (stage_wr),
    .cmd_valid    (nonempty),
    .cmd_in       (cmd_b),
    .take         (take),
    .idle         (idle),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

### rtl/sarm_front.sv
// ----------------------------------------------------------------------------
// sarm_front
// Counts and stages vector elements, computes the write gate and issues
// one command per last element or clear.
// ----------------------------------------------------------------------------
module sarm_front #(
  parameter int DIM = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  sarm_pkg::in_item_t  item,
  output sarm_pkg::stage_wr_t stage_wr,
  output logic                push,
  output sarm_pkg::cmd_t      cmd
);
  import sarm_pkg::*;

  localparam int EC_W = $clog2(DIM + 1);

  logic [EC_W-1:0]   cnt;
  logic [EC_W-1:0]   cnt_next;
  logic              is_elem;
  logic              room;
  logic [EC_W-1:0]   cnt_new;
  logic [4:0]        k;
  logic [GATE_W-1:0] t0;
  logic [GATE_W-1:0] t1;
  logic [20:0]       interp;
  logic [GATE_W-1:0] gate;

  assign is_elem = accept && (item.kind == KIND_QUERY || item.kind == KIND_WRITE);
  assign room    = cnt < EC_W'(DIM);
  assign cnt_new = room ? cnt + EC_W'(1) : cnt;

  assign k      = {1'b0, item.surprise[13:10]};
  assign t0     = tanh_lut(k);
  assign t1     = tanh_lut(k + 5'd1);
  assign interp = 21'(t1 - t0) * 21'(item.surprise[9:0]) + 21'd512;
  assign gate   = (item.surprise[15:14] != 2'd0) ? tanh_lut(5'd16)
                                                 : t0 + GATE_W'(interp >> 10);

  always_comb begin
    stage_wr.en  = is_elem && room;
    stage_wr.idx = IDX_W'(cnt);
    stage_wr.val = item.element_value;
    push         = 1'b0;
    cmd.op       = OP_CLEAR;
    cmd.cnt      = CNT_W'(cnt_new);
    cmd.gate     = gate;
    cnt_next     = cnt;
    if (accept && item.kind == KIND_CLEAR) begin
      push     = 1'b1;
      cnt_next = '0;
    end else if (is_elem) begin
      cmd.op = (item.kind == KIND_QUERY) ? OP_READ : OP_WRITE;
      if (item.last_element) begin
        push     = 1'b1;
        cnt_next = '0;
      end else begin
        cnt_next = cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

### rtl/sarm_cmd_q.sv
// ----------------------------------------------------------------------------
// sarm_cmd_q
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module sarm_cmd_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sarm_pkg::cmd_t din,
  input  logic           pop,
  output sarm_pkg::cmd_t dout,
  output logic           nonempty
);
  import sarm_pkg::*;

  cmd_t       ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;

  assign dout     = ent[rp];
  assign nonempty = fill != 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/sarm_back.sv
// ----------------------------------------------------------------------------
// sarm_back
// Executes read, write and clear commands over the slot memory: dot
// products, exp table, reciprocal divider, weighted sums and gated writes.
// ----------------------------------------------------------------------------
module sarm_back #(
  parameter int SLOTS = 16,
  parameter int DIM   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  sarm_pkg::stage_wr_t stage_wr,
  input  logic                cmd_valid,
  input  sarm_pkg::cmd_t      cmd_in,
  output logic                take,
  output logic                idle,
  output logic                result_valid,
  output sarm_pkg::out_item_t result
);
  import sarm_pkg::*;

  localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EC_W  = $clog2(DIM + 1);
  localparam int MEM_D = SLOTS * (1 << IW);
  localparam int LG_W  = 32 + $clog2(DIM);
  localparam int SUM_W = 16 + SW;
  localparam int AC_W  = 34 + SW + IW;

  back_state_t state;
  back_state_t state_next;

  logic signed [15:0]     slot_mem  [MEM_D];
  logic signed [15:0]     stage_mem [DIM];
  logic signed [LG_W-1:0] lgt_mem   [SLOTS];
  logic [15:0]            wt_mem    [SLOTS];
  logic [SLOTS-1:0]       row_valid;

  logic signed [15:0]     mem_q;
  logic signed [15:0]     stage_q;
  logic signed [LG_W-1:0] lgt_q;
  logic [15:0]            wt_q;

  logic [CNT_W-1:0]       qd;
  logic [GATE_W-1:0]      gate;
  logic [SW-1:0]          s;
  logic [EC_W-1:0]        e;
  logic [SW-1:0]          head;
  logic signed [31:0]     prod;
  logic signed [32:0]     prod2;
  logic signed [28:0]     wp;
  logic signed [AC_W-1:0] acc;
  logic signed [LG_W-1:0] top;
  logic [44:0]            dm;
  logic                   big;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       rem;
  logic [16:0]            recip;
  logic [5:0]             step;
  logic [32:0]            pm;

  logic                   s_last;
  logic                   e_last;
  logic signed [15:0]     mval;
  logic [LG_W:0]          diff;
  logic [28:0]            y;
  logic [15:0]            w;
  logic [SUM_W:0]         r2;
  logic signed [AC_W-1:0] rd_r;
  logic signed [16:0]     wr_r;
  logic signed [15:0]     rd_sat;
  logic signed [15:0]     wr_sat;
  logic                   emit;
  out_item_t              emit_item;

  assign s_last = s == SW'(SLOTS - 1);
  assign e_last = e == EC_W'(DIM - 1);
  assign mval   = row_valid[s] ? mem_q : 16'sd0;
  assign diff   = (LG_W+1)'(top) - (LG_W+1)'(lgt_q);
  assign y      = dm[44:16];
  assign w      = (big || y[28]) ? 16'd0 : exp2_lut(y[23:20]) >> y[27:24];
  assign r2     = {rem, step == 6'd0};
  assign rd_r   = (acc + AC_W'(32768)) >>> 16;
  assign wr_r   = 17'((wp + 29'sd2048) >>> 12);
  assign rd_sat = (rd_r > AC_W'(32767)) ? 16'sh7fff :
                  (rd_r < -AC_W'(32768)) ? -16'sh8000 : 16'(rd_r);
  assign wr_sat = (wr_r > 17'sd32767) ? 16'sh7fff :
                  (wr_r < -17'sd32768) ? -16'sh8000 : 16'(wr_r);

  assign idle = state == S_IDLE;
  assign take = idle && cmd_valid;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_item  = '0;
    emit_item.last_result = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_in.op)
            OP_READ:  state_next = S_DOT_RD;
            OP_WRITE: state_next = (cmd_in.gate == '0) ? S_WR_SKIP : S_WR_RD;
            default:  state_next = S_CLEAR;
          endcase
        end
      end
      S_CLEAR: begin
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      S_WR_SKIP: begin
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      S_DOT_RD:  state_next = (CNT_W'(e) >= qd) ? S_DOT_ST : S_DOT_MUL;
      S_DOT_MUL: state_next = S_DOT_ACC;
      S_DOT_ACC: state_next = S_DOT_RD;
      S_DOT_ST:  state_next = s_last ? S_EXP_RD : S_DOT_RD;
      S_EXP_RD:  state_next = S_EXP_MUL;
      S_EXP_MUL: state_next = S_EXP_W;
      S_EXP_W:   state_next = s_last ? S_DIV : S_EXP_RD;
      S_DIV:     state_next = (step == 6'd32) ? S_P_RD : S_DIV;
      S_P_RD:    state_next = S_P_MUL;
      S_P_MUL:   state_next = S_P_WR;
      S_P_WR:    state_next = s_last ? S_SUM_RD : S_P_RD;
      S_SUM_RD:  state_next = S_SUM_MUL;
      S_SUM_MUL: state_next = S_SUM_ACC;
      S_SUM_ACC: state_next = s_last ? S_EMIT : S_SUM_RD;
      S_EMIT: begin
        emit                  = 1'b1;
        emit_item.out_value   = rd_sat;
        emit_item.out_index   = 4'(e);
        emit_item.last_result = e_last;
        state_next            = e_last ? S_IDLE : S_SUM_RD;
      end
      S_WR_RD:  state_next = S_WR_MUL;
      S_WR_MUL: state_next = S_WR_ST;
      S_WR_ST: begin
        if (e_last) begin
          emit              = 1'b1;
          emit_item.written = 1'b1;
          state_next        = S_IDLE;
        end else begin
          state_next = S_WR_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_wr.en) begin
      stage_mem[stage_wr.idx[IW-1:0]] <= stage_wr.val;
    end
    stage_q <= stage_mem[e[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_WR_ST) begin
      slot_mem[{head, e[IW-1:0]}] <= wr_sat;
    end
    mem_q <= slot_mem[{s, e[IW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (state == S_DOT_ST) begin
      lgt_mem[s] <= LG_W'(acc);
    end
    lgt_q <= lgt_mem[s];
  end

  always_ff @(posedge clk) begin
    if (state == S_EXP_W) begin
      wt_mem[s] <= w;
    end else if (state == S_P_WR) begin
      wt_mem[s] <= pm[31:16];
    end
    wt_q <= wt_mem[s];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid    <= '0;
      head         <= '0;
      s            <= '0;
      e            <= '0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
      unique case (state)
        S_IDLE: begin
          s    <= '0;
          e    <= '0;
          step <= '0;
        end
        S_CLEAR: begin
          row_valid <= '0;
          head      <= '0;
        end
        S_DOT_ACC: e <= e + EC_W'(1);
        S_DOT_ST: begin
          e <= '0;
          s <= s_last ? '0 : s + SW'(1);
        end
        S_EXP_W: s <= s_last ? '0 : s + SW'(1);
        S_DIV:   step <= step + 6'd1;
        S_P_WR:  s <= s_last ? '0 : s + SW'(1);
        S_SUM_ACC: begin
          if (!s_last) begin
            s <= s + SW'(1);
          end
        end
        S_EMIT: begin
          s <= '0;
          e <= e + EC_W'(1);
        end
        S_WR_ST: begin
          e <= e + EC_W'(1);
          if (e_last) begin
            row_valid[head] <= 1'b1;
            head            <= (head == SW'(SLOTS - 1)) ? '0 : head + SW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    result <= emit_item;
    unique case (state)
      S_IDLE: begin
        qd   <= cmd_in.cnt;
        gate <= cmd_in.gate;
        acc  <= '0;
        sum  <= '0;
        rem  <= '0;
      end
      S_DOT_MUL: prod <= stage_q * mval;
      S_DOT_ACC: acc <= acc + AC_W'(prod);
      S_DOT_ST: begin
        if (s == '0 || LG_W'(acc) > top) begin
          top <= LG_W'(acc);
        end
        acc <= '0;
      end
      S_EXP_MUL: begin
        big <= |diff[LG_W:28];
        dm  <= 45'(diff[27:0]) * 45'(LOG2E_Q16);
      end
      S_EXP_W: sum <= sum + SUM_W'(w);
      S_DIV: begin
        if (r2 >= {1'b0, sum}) begin
          rem   <= SUM_W'(r2 - {1'b0, sum});
          recip <= {recip[15:0], 1'b1};
        end else begin
          rem   <= SUM_W'(r2);
          recip <= {recip[15:0], 1'b0};
        end
      end
      S_P_MUL:   pm <= 33'(wt_q) * 33'(recip);
      S_SUM_MUL: prod2 <= $signed({1'b0, wt_q}) * mval;
      S_SUM_ACC: acc <= acc + AC_W'(prod2);
      S_EMIT:    acc <= '0;
      S_WR_MUL: begin
        if (CNT_W'(e) < qd) begin
          wp <= $signed({1'b0, gate}) * stage_q;
        end else begin
          wp <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
